// ===== hw/rtl/sdms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sdms_pkg;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;  // place the broadcast item, cells below it shift down
    logic shift;   // every cell takes its lower neighbor, cell 0 leaves as a beat
    logic flush;   // drop all held entries
  } sdms_cell_ctrl_t;

  // byte-aligned width of the output tdata: 32-bit key then 16-bit payload
  localparam int unsigned OutKeyW  = 32;
  localparam int unsigned OutPayW  = 16;
  localparam int unsigned OutDataW = ((OutKeyW + OutPayW + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== hw/rtl/sdms_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sdms_cell
  import sdms_pkg::*;
#(
  parameter int unsigned KEY_WIDTH     = 32,
  parameter int unsigned PAYLOAD_WIDTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire sdms_cell_ctrl_t          ctrl_i,
  input  wire logic [KEY_WIDTH-1:0]     new_key_i,
  input  wire logic [PAYLOAD_WIDTH-1:0] new_pay_i,
  input  wire logic                     up_less_i,
  input  wire logic                     up_valid_i,
  input  wire logic [KEY_WIDTH-1:0]     up_key_i,
  input  wire logic [PAYLOAD_WIDTH-1:0] up_pay_i,
  input  wire logic                     dn_valid_i,
  input  wire logic [KEY_WIDTH-1:0]     dn_key_i,
  input  wire logic [PAYLOAD_WIDTH-1:0] dn_pay_i,
  output logic                          less_o,
  output logic                          valid_o,
  output logic [KEY_WIDTH-1:0]          key_o,
  output logic [PAYLOAD_WIDTH-1:0]      pay_o
);

  logic                     valid_q, valid_d;
  logic [KEY_WIDTH-1:0]     key_q, key_d;
  logic [PAYLOAD_WIDTH-1:0] pay_q, pay_d;

  // an empty cell or a strictly smaller key gives way; equal keys stay ahead
  assign less_o = !valid_q || (key_q < new_key_i);

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    pay_d   = pay_q;
    priority if (ctrl_i.flush) begin
      valid_d = 1'b0;
    end else if (ctrl_i.shift) begin
      valid_d = dn_valid_i;
      key_d   = dn_key_i;
      pay_d   = dn_pay_i;
    end else if (ctrl_i.insert && less_o) begin
      if (up_less_i) begin
        valid_d = up_valid_i;
        key_d   = up_key_i;
        pay_d   = up_pay_i;
      end else begin
        valid_d = 1'b1;
        key_d   = new_key_i;
        pay_d   = new_pay_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign pay_o   = pay_q;

endmodule

`default_nettype wire

// ===== hw/rtl/stable_descending_merge_sorter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Stable descending sorter built as a row of DEPTH insertion cells.
// Input stream: one beat per item, tdata carries key (low bits) and payload,
// tlast marks the final item of a set. Each accepted beat, while the chain has
// room, is placed into it in the same cycle, so loading runs at one item per cycle.
// Output stream: from the cycle after the tlast beat the block emits the set
// from cell 0, largest key first, equal keys in load order, one beat per
// cycle while the receiver is ready; tlast marks the last one.
// A set is fully loaded before it drains; the chain shifts once per output beat.
// The input is ready again in the cycle after the last output beat and is
// not ready while a set is being drained.
// More than DEPTH items in a set: the extra items are dropped, and at tlast a
// single beat with zero data, tuser (overflow) high and tlast high is given.
// A stalled receiver simply holds the chain and the current beat stable.
// Reset empties the chain and the item count; the block then takes input.

module stable_descending_merge_sorter_core
  import sdms_pkg::*;
#(
  parameter int unsigned DEPTH         = 64,
  parameter int unsigned KEY_WIDTH     = 32,
  parameter int unsigned PAYLOAD_WIDTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   s_axis_tvalid,
  output logic                                        s_axis_tready,
  // fields from bit 0: sort_key, payload
  input  wire logic [((KEY_WIDTH+PAYLOAD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  wire logic                                   s_axis_tlast,  // last_item
  output logic                                        m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  // fields from bit 0: out_key, out_payload
  output logic [OutDataW-1:0]                         m_axis_tdata,
  output logic                                        m_axis_tlast,  // end_of_set
  output logic                                        m_axis_tuser   // overflow_error
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  localparam logic [1:0] StLoad = 2'd0;
  localparam logic [1:0] StEmit = 2'd1;
  localparam logic [1:0] StErr  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;

  logic in_beat, out_beat, room;
  sdms_cell_ctrl_t ctrl;

  logic [KEY_WIDTH-1:0]     new_key;
  logic [PAYLOAD_WIDTH-1:0] new_pay;

  logic                     less_w  [DEPTH];
  logic                     valid_w [DEPTH];
  logic [KEY_WIDTH-1:0]     key_w   [DEPTH];
  logic [PAYLOAD_WIDTH-1:0] pay_w   [DEPTH];

  logic [63:0] key_ext;
  logic [63:0] pay_ext;

  assign new_key = s_axis_tdata[KEY_WIDTH-1:0];
  assign new_pay = s_axis_tdata[KEY_WIDTH +: PAYLOAD_WIDTH];

  assign s_axis_tready = (state_q == StLoad);
  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;
  assign room     = (cnt_q < CntW'(DEPTH));

  always_comb begin
    ctrl.insert = in_beat && room;
    ctrl.shift  = out_beat && (state_q == StEmit);
    ctrl.flush  = out_beat && (state_q == StErr);
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    unique case (state_q)
      StLoad: begin
        if (in_beat) begin
          if (room) begin
            cnt_d = cnt_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = (ovf_q || !room) ? StErr : StEmit;
          end
        end
      end
      StEmit: begin
        if (out_beat && m_axis_tlast) begin
          state_d = StLoad;
        end
      end
      StErr: begin
        if (out_beat) begin
          state_d = StLoad;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     up_less, up_valid, dn_valid;
    logic [KEY_WIDTH-1:0]     up_key, dn_key;
    logic [PAYLOAD_WIDTH-1:0] up_pay, dn_pay;

    if (i == 0) begin : g_head
      assign up_less  = 1'b0;
      assign up_valid = 1'b0;
      assign up_key   = '0;
      assign up_pay   = '0;
    end else begin : g_mid_up
      assign up_less  = less_w[i-1];
      assign up_valid = valid_w[i-1];
      assign up_key   = key_w[i-1];
      assign up_pay   = pay_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign dn_valid = 1'b0;
      assign dn_key   = '0;
      assign dn_pay   = '0;
    end else begin : g_mid_dn
      assign dn_valid = valid_w[i+1];
      assign dn_key   = key_w[i+1];
      assign dn_pay   = pay_w[i+1];
    end

    sdms_cell #(
      .KEY_WIDTH    (KEY_WIDTH),
      .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .new_key_i (new_key),
      .new_pay_i (new_pay),
      .up_less_i (up_less),
      .up_valid_i(up_valid),
      .up_key_i  (up_key),
      .up_pay_i  (up_pay),
      .dn_valid_i(dn_valid),
      .dn_key_i  (dn_key),
      .dn_pay_i  (dn_pay),
      .less_o    (less_w[i]),
      .valid_o   (valid_w[i]),
      .key_o     (key_w[i]),
      .pay_o     (pay_w[i])
    );
  end

  // output fields are fixed at 32 and 16 bits whatever the stored widths
  assign key_ext = 64'(key_w[0]);
  assign pay_ext = 64'(pay_w[0]);

  assign m_axis_tvalid = (state_q == StEmit) || (state_q == StErr);
  assign m_axis_tuser  = (state_q == StErr);
  assign m_axis_tlast  = (state_q == StErr) || !valid_w[1];

  always_comb begin
    m_axis_tdata = '0;
    if (state_q == StEmit) begin
      m_axis_tdata = OutDataW'({pay_ext[OutPayW-1:0], key_ext[OutKeyW-1:0]});
    end
  end

endmodule

`default_nettype wire
